>>> design/binary_min_heap_macros.svh
// assertion macros for the binary min-heap
// no dependencies; taken in by files that carry assertions
`ifndef BINARY_MIN_HEAP_MACROS_SVH
`define BINARY_MIN_HEAP_MACROS_SVH

`ifndef ASSERT_OFF
`define BMH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("binary_min_heap: assertion failed");
`define BMH_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("binary_min_heap: forbidden condition seen");
`else
`define BMH_ASSERT(lbl, clk, rstn, prop)
`define BMH_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> design/bmh_pkg.sv
// shared types and codes for the binary min-heap
// no dependencies; used by controller, datapath and top level
package bmh_pkg;

    localparam int KEY_W     = 63;
    localparam int CNT_OUT_W = 11;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key_in;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]     removed_key;
        logic [KEY_W-1:0]     min_key;
        logic [CNT_OUT_W-1:0] entry_count_out;
        logic                 is_empty;
        logic [1:0]           status;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP_LOAD,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_FINISH
    } ctl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_REJECT,
        DP_PUSH_START,
        DP_POP_START,
        DP_POP_LOAD,
        DP_PLACE,
        DP_UP_READ,
        DP_UP_STEP,
        DP_DOWN_READ,
        DP_DOWN_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic last_one;
        logic pos_zero;
        logic leaf;
        logic up_move;
        logic down_move;
    } dp_flags_t;

endpackage

>>> design/bmh_ram.sv
// generic simple ram: one write port, two registered read ports
// no dependencies
module bmh_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

>>> design/bmh_datapath.sv
// heap datapath: key store, moving key, position, count and result word
// depends on bmh_pkg and bmh_ram
module bmh_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmh_pkg::in_word_t  s_word,
    input  bmh_pkg::dp_cmd_t   cmd,
    output bmh_pkg::dp_flags_t flags,
    output bmh_pkg::out_word_t m_word
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic                        func_reg, func_next;
    logic [bmh_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [bmh_pkg::KEY_W-1:0]   min_reg, min_next;
    logic [bmh_pkg::KEY_W-1:0]   removed_reg, removed_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [CW-1:0]               count_reg, count_next;
    bmh_pkg::status_t            status_reg, status_next;
    bmh_pkg::out_word_t          result_reg;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [bmh_pkg::KEY_W-1:0]   wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_a_addr;
    logic [AW-1:0]               rd_b_addr;
    logic [bmh_pkg::KEY_W-1:0]   rd_a_data;
    logic [bmh_pkg::KEY_W-1:0]   rd_b_data;

    logic [IW-1:0]               l_idx;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               cnt_ext;
    logic [AW-1:0]               parent;
    logic                        r_ok;
    logic                        left_less;
    logic                        right_less;
    logic [bmh_pkg::KEY_W-1:0]   best_key;
    logic [bmh_pkg::KEY_W-1:0]   child_key;
    logic [AW-1:0]               child_pos;

    bmh_ram #(
        .WIDTH (bmh_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // child and parent positions
    assign l_idx   = IW'({pos_reg, 1'b1});
    assign r_idx   = l_idx + IW'(1);
    assign cnt_ext = IW'(count_reg);
    assign parent  = (pos_reg - AW'(1)) >> 1;
    assign r_ok    = r_idx < cnt_ext;

    // pick the smaller child if it beats the moving key
    assign left_less  = rd_a_data < key_reg;
    assign best_key   = left_less ? rd_a_data : key_reg;
    assign right_less = r_ok && (rd_b_data < best_key);
    assign child_key  = right_less ? rd_b_data : rd_a_data;
    assign child_pos  = right_less ? r_idx[AW-1:0] : l_idx[AW-1:0];

    assign flags.is_pop    = (func_reg == bmh_pkg::FUNC_POP);
    assign flags.empty     = (count_reg == '0);
    assign flags.full      = (count_reg == CW'(CAPACITY));
    assign flags.last_one  = (count_reg == CW'(1));
    assign flags.pos_zero  = (pos_reg == '0);
    assign flags.leaf      = (l_idx >= cnt_ext);
    assign flags.up_move   = (key_reg < rd_a_data);
    assign flags.down_move = left_less || right_less;

    always_comb begin
        func_next    = func_reg;
        key_next     = key_reg;
        removed_next = removed_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;
        rd_en        = 1'b0;
        rd_a_addr    = l_idx[AW-1:0];
        rd_b_addr    = r_idx[AW-1:0];
        case (cmd.op)
            bmh_pkg::DP_ACCEPT: begin
                func_next    = s_word.func;
                key_next     = s_word.key_in;
                removed_next = '0;
                status_next  = bmh_pkg::ST_OK;
            end
            bmh_pkg::DP_REJECT: begin
                status_next = (func_reg == bmh_pkg::FUNC_POP) ?
                              bmh_pkg::ST_POP_EMPTY : bmh_pkg::ST_PUSH_FULL;
            end
            bmh_pkg::DP_PUSH_START: begin
                pos_next   = count_reg[AW-1:0];
                count_next = count_reg + CW'(1);
            end
            bmh_pkg::DP_POP_START: begin
                removed_next = min_reg;
                count_next   = count_reg - CW'(1);
                rd_en        = 1'b1;
                rd_a_addr    = AW'(count_reg - CW'(1));
            end
            bmh_pkg::DP_POP_LOAD: begin
                key_next = rd_a_data;
                pos_next = '0;
            end
            bmh_pkg::DP_PLACE: begin
                wr_en = 1'b1;
            end
            bmh_pkg::DP_UP_READ: begin
                rd_en     = 1'b1;
                rd_a_addr = parent;
            end
            bmh_pkg::DP_UP_STEP: begin
                wr_en = 1'b1;
                if (key_reg < rd_a_data) begin
                    wr_data  = rd_a_data;
                    pos_next = parent;
                end
            end
            bmh_pkg::DP_DOWN_READ: begin
                rd_en = 1'b1;
            end
            bmh_pkg::DP_DOWN_STEP: begin
                wr_en = 1'b1;
                if (left_less || right_less) begin
                    wr_data  = child_key;
                    pos_next = child_pos;
                end
            end
            default: begin
            end
        endcase
    end

    // root copy kept beside the ram
    assign min_next = (wr_en && (wr_addr == '0)) ? wr_data : min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        removed_reg <= removed_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        min_reg     <= min_next;
        if (cmd.out_load) begin
            result_reg.removed_key     <= removed_reg;
            result_reg.min_key         <= (count_reg != '0) ? min_reg : '0;
            result_reg.entry_count_out <= bmh_pkg::CNT_OUT_W'(count_reg);
            result_reg.is_empty        <= (count_reg == '0);
            result_reg.status          <= status_reg;
        end
    end

    assign m_word = result_reg;

endmodule

>>> design/bmh_ctrl.sv
// heap controller: sequences push sift-up and pop sift-down, owns handshakes
// depends on bmh_pkg
module bmh_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  bmh_pkg::dp_flags_t flags,
    output bmh_pkg::dp_cmd_t   cmd
);

    bmh_pkg::ctl_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmh_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = bmh_pkg::DP_NOP;
        cmd.out_load = 1'b0;
        case (state_reg)
            bmh_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = bmh_pkg::DP_ACCEPT;
                    state_next = bmh_pkg::S_CHECK;
                end
            end
            bmh_pkg::S_CHECK: begin
                if (flags.is_pop) begin
                    if (flags.empty) begin
                        cmd.op     = bmh_pkg::DP_REJECT;
                        state_next = bmh_pkg::S_FINISH;
                    end else begin
                        cmd.op     = bmh_pkg::DP_POP_START;
                        state_next = flags.last_one ? bmh_pkg::S_FINISH
                                                    : bmh_pkg::S_POP_LOAD;
                    end
                end else begin
                    if (flags.full) begin
                        cmd.op     = bmh_pkg::DP_REJECT;
                        state_next = bmh_pkg::S_FINISH;
                    end else begin
                        cmd.op     = bmh_pkg::DP_PUSH_START;
                        state_next = bmh_pkg::S_UP_RD;
                    end
                end
            end
            bmh_pkg::S_POP_LOAD: begin
                cmd.op     = bmh_pkg::DP_POP_LOAD;
                state_next = bmh_pkg::S_DOWN_RD;
            end
            bmh_pkg::S_DOWN_RD: begin
                if (flags.leaf) begin
                    cmd.op     = bmh_pkg::DP_PLACE;
                    state_next = bmh_pkg::S_FINISH;
                end else begin
                    cmd.op     = bmh_pkg::DP_DOWN_READ;
                    state_next = bmh_pkg::S_DOWN_CMP;
                end
            end
            bmh_pkg::S_DOWN_CMP: begin
                cmd.op     = bmh_pkg::DP_DOWN_STEP;
                state_next = flags.down_move ? bmh_pkg::S_DOWN_RD : bmh_pkg::S_FINISH;
            end
            bmh_pkg::S_UP_RD: begin
                if (flags.pos_zero) begin
                    cmd.op     = bmh_pkg::DP_PLACE;
                    state_next = bmh_pkg::S_FINISH;
                end else begin
                    cmd.op     = bmh_pkg::DP_UP_READ;
                    state_next = bmh_pkg::S_UP_CMP;
                end
            end
            bmh_pkg::S_UP_CMP: begin
                cmd.op     = bmh_pkg::DP_UP_STEP;
                state_next = flags.up_move ? bmh_pkg::S_UP_RD : bmh_pkg::S_FINISH;
            end
            bmh_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = bmh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bmh_pkg::S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == bmh_pkg::S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> design/binary_min_heap.sv
// binary min-heap priority queue, one push or pop per word
// push sifts the new key up toward the root; pop moves the last entry to the root
// and sifts it down; rejected words and the pop of the last entry skip the sift
// one word at a time: the next word is taken from the cycle after the result loads
// reset: count cleared, heap empty; ram contents are not cleared
module binary_min_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bmh_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output bmh_pkg::out_word_t m_word
);

`include "binary_min_heap_macros.svh"

    bmh_pkg::dp_cmd_t   cmd;
    bmh_pkg::dp_flags_t flags;

    bmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    bmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .flags   (flags),
        .m_word  (m_word)
    );

    `BMH_ASSERT(a_one_word_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `BMH_ASSERT(a_pop_empty_result, aclk, aresetn,
        (m_valid && (m_word.status == bmh_pkg::ST_POP_EMPTY)) |->
        (m_word.is_empty && (m_word.removed_key == '0)))
    `BMH_ASSERT(a_push_full_result, aclk, aresetn,
        (m_valid && (m_word.status == bmh_pkg::ST_PUSH_FULL)) |->
        (!m_word.is_empty && (m_word.removed_key == '0)))
    `BMH_ASSERT_NEVER(a_empty_min_zero, aclk, aresetn,
        m_valid && m_word.is_empty && (m_word.min_key != '0))

endmodule

>>> verif/tb.sv
// self-checking testbench for binary_min_heap: push/pop words checked field by field
// against a heap model kept here or a row's literal word; directed table first, then
// random traffic; depends on bmh_pkg and the binary_min_heap design files
module tb;

    localparam int CAPACITY = 1024;
    localparam int DIR_N = 25;
    localparam int LIMIT = 400000;
    localparam int HOLD_AT = 3000;
    localparam int HOLD_LEN = 400;
    localparam int CALM_LO = 10000;
    localparam int CALM_HI = 16000;
    localparam logic [bmh_pkg::KEY_W-1:0] KEY_MAX = '1;

    typedef struct packed {
        logic                      func;
        logic [bmh_pkg::KEY_W-1:0] key;
        logic                      lit;
        bmh_pkg::out_word_t        lit_word;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b1,
          '{63'd0, 63'd0, 11'd0, 1'b1, bmh_pkg::ST_POP_EMPTY}},
        '{bmh_pkg::FUNC_PUSH, KEY_MAX, 1'b1,
          '{63'd0, KEY_MAX, 11'd1, 1'b0, bmh_pkg::ST_OK}},
        '{bmh_pkg::FUNC_PUSH, 63'd0,   1'b1,
          '{63'd0, 63'd0, 11'd2, 1'b0, bmh_pkg::ST_OK}},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b1,
          '{63'd0, KEY_MAX, 11'd1, 1'b0, bmh_pkg::ST_OK}},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b1,
          '{KEY_MAX, 63'd0, 11'd0, 1'b1, bmh_pkg::ST_OK}},
        '{bmh_pkg::FUNC_POP,  KEY_MAX, 1'b1,
          '{63'd0, 63'd0, 11'd0, 1'b1, bmh_pkg::ST_POP_EMPTY}},
        '{bmh_pkg::FUNC_PUSH, 63'd7,   1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'd3,   1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'd9,   1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'd3,   1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'd1,   1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, KEY_MAX, 1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'h5555_5555_5555_5555, 1'b0, '0},
        '{bmh_pkg::FUNC_PUSH, 63'd5,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  KEY_MAX, 1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b0, '0},
        '{bmh_pkg::FUNC_POP,  63'd0,   1'b1,
          '{63'd0, 63'd0, 11'd0, 1'b1, bmh_pkg::ST_POP_EMPTY}}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bmh_pkg::in_word_t  s_word = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bmh_pkg::out_word_t m_word;

    logic [bmh_pkg::KEY_W-1:0] heap_keys [CAPACITY];
    int                        heap_count = 0;
    bmh_pkg::out_word_t        pending_results [$];
    bmh_pkg::out_word_t        due_word;
    int                        fail_count = 0;
    int                        cycle = 0;
    int                        hold_left = 0;
    int                        words_sent = 0;

    binary_min_heap #(.CAPACITY(CAPACITY)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #10 aclk = ~aclk;

    // heap model: applies one word and returns the result word it should give
    function automatic bmh_pkg::out_word_t heap_apply(input logic f,
                                                      input logic [bmh_pkg::KEY_W-1:0] k);
        bmh_pkg::out_word_t        r;
        int                        pos;
        int                        par;
        int                        best;
        int                        lc;
        logic                      moving;
        logic [bmh_pkg::KEY_W-1:0] t;
        r = '0;
        r.status = bmh_pkg::ST_OK;
        if (f == bmh_pkg::FUNC_PUSH) begin
            if (heap_count >= CAPACITY) begin
                r.status = bmh_pkg::ST_PUSH_FULL;
            end else begin
                pos = heap_count;
                heap_keys[pos] = k;
                heap_count++;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    par = (pos - 1) / 2;
                    if (heap_keys[pos] < heap_keys[par]) begin
                        t = heap_keys[pos];
                        heap_keys[pos] = heap_keys[par];
                        heap_keys[par] = t;
                        pos = par;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                r.status = bmh_pkg::ST_POP_EMPTY;
            end else begin
                r.removed_key = heap_keys[0];
                heap_count--;
                heap_keys[0] = heap_keys[heap_count];
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    best = pos;
                    lc = 2 * pos + 1;
                    if (lc < heap_count && heap_keys[lc] < heap_keys[best])
                        best = lc;
                    if (lc + 1 < heap_count && heap_keys[lc + 1] < heap_keys[best])
                        best = lc + 1;
                    if (best == pos) begin
                        moving = 1'b0;
                    end else begin
                        t = heap_keys[best];
                        heap_keys[best] = heap_keys[pos];
                        heap_keys[pos] = t;
                        pos = best;
                    end
                end
            end
        end
        r.min_key = (heap_count > 0) ? heap_keys[0] : '0;
        r.entry_count_out = bmh_pkg::CNT_OUT_W'(heap_count);
        r.is_empty = (heap_count == 0);
        return r;
    endfunction

    function automatic logic [bmh_pkg::KEY_W-1:0] pick_key();
        logic [bmh_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2: k = bmh_pkg::KEY_W'($urandom_range(0, 15));
            3: k = '0;
            4: k = KEY_MAX;
            default: k = bmh_pkg::KEY_W'({$urandom, $urandom});
        endcase
        return k;
    endfunction

    task automatic send_word(input logic f, input logic [bmh_pkg::KEY_W-1:0] k,
                             input logic lit, input bmh_pkg::out_word_t lit_word);
        bmh_pkg::out_word_t pred;
        while (!(words_sent >= 400 && words_sent < 700) && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= '{func: f, key_in: k};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = heap_apply(f, k);
        words_sent++;
        pending_results.push_back(lit ? lit_word : pred);
    endtask

    task automatic send_mix(input int n, input int pop_pct);
        for (int i = 0; i < n; i++)
            send_word(($urandom_range(0, 99) < pop_pct) ? bmh_pkg::FUNC_POP
                                                        : bmh_pkg::FUNC_PUSH,
                      pick_key(), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [63:0] e,
                                 input logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
            fail_count++;
        end
    endtask

    // receiver: random stalls, one long hold-off, one stall-free window
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (cycle == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (cycle >= CALM_LO && cycle < CALM_HI) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h", $time, m_word);
                fail_count++;
            end else begin
                due_word = pending_results.pop_front();
                compare_field("removed_key", due_word.removed_key, m_word.removed_key);
                compare_field("min_key", due_word.min_key, m_word.min_key);
                compare_field("entry_count_out", due_word.entry_count_out,
                              m_word.entry_count_out);
                compare_field("is_empty", due_word.is_empty, m_word.is_empty);
                compare_field("status", due_word.status, m_word.status);
            end
        end
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT) begin
            $display("binary_min_heap verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIR_N; i++)
            send_word(DIR_ROWS[i].func, DIR_ROWS[i].key, DIR_ROWS[i].lit,
                      DIR_ROWS[i].lit_word);
        // balanced traffic from empty, then fill up and work at the full mark
        send_mix(20, 50);
        while (heap_count < CAPACITY)
            send_mix(1, 3);
        send_mix(30, 45);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("binary_min_heap verification clean");
        end else begin
            $display("binary_min_heap verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bmh_pkg.sv
design/bmh_ram.sv
design/bmh_datapath.sv
design/bmh_ctrl.sv
design/binary_min_heap.sv
verif/tb.sv
